// File: rtl/core/i2c_mbe_pkg.sv
// Shared constants and types for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none

package i2c_mbe_pkg;

	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned DELAY_W = 10;
	localparam int unsigned BITCNT_W = 4;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned OUT_W   = 16;

	// command codes
	localparam logic [FUNC_W-1:0] CMD_NONE  = 3'd0;
	localparam logic [FUNC_W-1:0] CMD_START = 3'd1;
	localparam logic [FUNC_W-1:0] CMD_STOP  = 3'd2;
	localparam logic [FUNC_W-1:0] CMD_WRITE = 3'd3;
	localparam logic [FUNC_W-1:0] CMD_READ  = 3'd4;
	localparam logic [FUNC_W-1:0] CMD_WACK  = 3'd5;
	localparam logic [FUNC_W-1:0] CMD_ACK   = 3'd6;
	localparam logic [FUNC_W-1:0] CMD_NACK  = 3'd7;

	// sequence steps
	localparam logic [PHASE_W-1:0] PH_0 = 4'd0;
	localparam logic [PHASE_W-1:0] PH_1 = 4'd1;
	localparam logic [PHASE_W-1:0] PH_2 = 4'd2;
	localparam logic [PHASE_W-1:0] PH_3 = 4'd3;
	localparam logic [PHASE_W-1:0] PH_4 = 4'd4;

	// configuration register indexes
	localparam logic REG_UNIT_TICKS  = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	localparam logic [CFG_W-1:0]    UNIT_TICKS_RST  = 8'd32;
	localparam logic [CFG_W-1:0]    ACK_TIMEOUT_RST = 8'd250;
	localparam logic [7:0]          POLL_MAX        = 8'hFF;
	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE   = 4'd8;

	// result word, lowest bit first: scl, sda, driven, busy, done, rx_byte, ack_failed
	typedef struct packed {
		logic [1:0] pad;
		logic       ack_failed;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_driven;
		logic       sda_level;
		logic       scl_level;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/core/i2c_master_bit_engine.sv
// I2C master bit engine: command sequencer for SCL/SDA, one tick per request.
// The result of a request is registered and shown in the cycle after acceptance.
// Throughput: one request per cycle; s_axis_tready drops only while the result
// register holds a result that m_axis has not taken.
// All command steps of a tick are resolved by the next-state logic in front of the
// state registers. Reset (arst_n low) drives SCL and SDA high, SDA driven, engine idle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [2:0] func, [10:3] tx_byte, [11] sda_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] scl_level, [1] sda_level, [2] sda_driven, [3] busy_res, [4] done_res,
	// [12:5] rx_byte, [13] ack_failed
	output logic [15:0]      m_axis_tdata,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	// configuration
	logic [7:0] unit_ticks_q, ack_timeout_q;

	// engine state
	logic                                 scl_q, sda_q, dir_q, fail_q;
	logic [i2c_mbe_pkg::FUNC_W-1:0]       cmd_q;
	logic [i2c_mbe_pkg::PHASE_W-1:0]      phase_q;
	logic [i2c_mbe_pkg::DELAY_W-1:0]      delay_q;
	logic [i2c_mbe_pkg::BITCNT_W-1:0]     bit_q;
	logic [7:0]                           shift_q, poll_q, rx_q;

	logic                                 scl_d, sda_d, dir_d, fail_d, done_d;
	logic [i2c_mbe_pkg::FUNC_W-1:0]       cmd_d;
	logic [i2c_mbe_pkg::PHASE_W-1:0]      phase_d;
	logic [i2c_mbe_pkg::DELAY_W-1:0]      delay_d;
	logic [i2c_mbe_pkg::BITCNT_W-1:0]     bit_d, bit_inc;
	logic [7:0]                           shift_d, poll_d, rx_d, poll_inc;

	logic                                 m_valid_q;
	i2c_mbe_pkg::res_t                    res_q, res_d;

	logic                                 in_fire, run, ut_zero, accept_cmd;
	logic [i2c_mbe_pkg::FUNC_W-1:0]       func_in;
	logic [7:0]                           tx_in;
	logic                                 sda_in;
	logic [i2c_mbe_pkg::DELAY_W-1:0]      dly1, dly2, dly4;

	assign func_in = s_axis_tdata[2:0];
	assign tx_in   = s_axis_tdata[10:3];
	assign sda_in  = s_axis_tdata[11];

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = res_q;

	assign ut_zero = (unit_ticks_q == 8'd0);
	assign dly1    = {2'b00, unit_ticks_q};
	assign dly2    = {1'b0, unit_ticks_q, 1'b0};
	assign dly4    = {unit_ticks_q, 2'b00};

	always_comb begin
		scl_d      = scl_q;
		sda_d      = sda_q;
		dir_d      = dir_q;
		fail_d     = fail_q;
		cmd_d      = cmd_q;
		phase_d    = phase_q;
		delay_d    = delay_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		poll_d     = poll_q;
		rx_d       = rx_q;
		done_d     = 1'b0;
		run        = 1'b0;
		accept_cmd = 1'b0;
		bit_inc    = bit_q + 4'd1;
		poll_inc   = poll_q;

		if (in_fire) begin
			if (cmd_q == i2c_mbe_pkg::CMD_NONE) begin
				if (func_in != i2c_mbe_pkg::CMD_NONE) begin
					cmd_d      = func_in;
					phase_d    = i2c_mbe_pkg::PH_0;
					delay_d    = '0;
					bit_d      = '0;
					poll_d     = '0;
					shift_d    = (func_in == i2c_mbe_pkg::CMD_WRITE) ? tx_in : 8'd0;
					run        = 1'b1;
					accept_cmd = 1'b1;
				end
			end else if (delay_q != '0) begin
				delay_d = delay_q - 10'd1;
				run     = (delay_q == 10'd1);
			end else begin
				run = 1'b1;
			end
		end

		bit_inc  = bit_d + 4'd1;
		poll_inc = (poll_d != i2c_mbe_pkg::POLL_MAX) ? poll_d + 8'd1 : poll_d;

		if (run && ut_zero && accept_cmd) begin
			// zero-length delays: settles in this tick; a WACK may go on polling
			case (cmd_d)
				i2c_mbe_pkg::CMD_START: begin
					dir_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0; done_d = 1'b1;
				end
				i2c_mbe_pkg::CMD_STOP: begin
					dir_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; done_d = 1'b1;
				end
				i2c_mbe_pkg::CMD_WRITE: begin
					dir_d = 1'b1; scl_d = 1'b0; sda_d = tx_in[0];
					shift_d = 8'd0; bit_d = i2c_mbe_pkg::BITS_PER_BYTE; done_d = 1'b1;
				end
				i2c_mbe_pkg::CMD_READ: begin
					dir_d = 1'b0; scl_d = 1'b1; shift_d = {8{sda_in}};
					rx_d = {8{sda_in}}; bit_d = i2c_mbe_pkg::BITS_PER_BYTE; done_d = 1'b1;
				end
				i2c_mbe_pkg::CMD_WACK: begin
					dir_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
					if (!sda_in) begin
						scl_d = 1'b0; fail_d = 1'b0; done_d = 1'b1;
					end else begin
						poll_d = 8'd1;
						if (ack_timeout_q == 8'd0) begin
							fail_d = 1'b1; dir_d = 1'b1; sda_d = 1'b1; done_d = 1'b1;
						end else begin
							phase_d = i2c_mbe_pkg::PH_2;
						end
					end
				end
				i2c_mbe_pkg::CMD_ACK, i2c_mbe_pkg::CMD_NACK: begin
					dir_d = 1'b1; scl_d = 1'b0; done_d = 1'b1;
					sda_d = (cmd_d == i2c_mbe_pkg::CMD_NACK);
				end
				default: begin
					done_d = 1'b1;
				end
			endcase
		end else if (run) begin
			case (cmd_d)
				i2c_mbe_pkg::CMD_START: begin
					if (phase_d == i2c_mbe_pkg::PH_0) begin
						dir_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
						delay_d = dly4; phase_d = i2c_mbe_pkg::PH_1;
					end else if (phase_d == i2c_mbe_pkg::PH_1) begin
						sda_d = 1'b0; delay_d = dly4; phase_d = i2c_mbe_pkg::PH_2;
					end else begin
						scl_d = 1'b0; done_d = 1'b1;
					end
				end
				i2c_mbe_pkg::CMD_STOP: begin
					if (phase_d == i2c_mbe_pkg::PH_0) begin
						dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
						delay_d = dly4; phase_d = i2c_mbe_pkg::PH_1;
					end else if (phase_d == i2c_mbe_pkg::PH_1) begin
						scl_d = 1'b1; sda_d = 1'b1; delay_d = dly4; phase_d = i2c_mbe_pkg::PH_2;
					end else begin
						done_d = 1'b1;
					end
				end
				i2c_mbe_pkg::CMD_WRITE: begin
					if (phase_d == i2c_mbe_pkg::PH_0 || phase_d == i2c_mbe_pkg::PH_1) begin
						// first step falls straight through into the first data bit
						if (phase_d == i2c_mbe_pkg::PH_0) begin
							dir_d = 1'b1; scl_d = 1'b0;
						end
						sda_d   = shift_d[7];
						shift_d = {shift_d[6:0], 1'b0};
						delay_d = dly2; phase_d = i2c_mbe_pkg::PH_2;
					end else if (phase_d == i2c_mbe_pkg::PH_2) begin
						scl_d = 1'b1; delay_d = dly2; phase_d = i2c_mbe_pkg::PH_3;
					end else if (phase_d == i2c_mbe_pkg::PH_3) begin
						scl_d = 1'b0; bit_d = bit_inc; delay_d = dly2;
						phase_d = (bit_inc < i2c_mbe_pkg::BITS_PER_BYTE) ?
							i2c_mbe_pkg::PH_1 : i2c_mbe_pkg::PH_4;
					end else begin
						done_d = 1'b1;
					end
				end
				i2c_mbe_pkg::CMD_READ: begin
					if (phase_d == i2c_mbe_pkg::PH_0 || phase_d == i2c_mbe_pkg::PH_1) begin
						if (phase_d == i2c_mbe_pkg::PH_0) begin
							dir_d = 1'b0; shift_d = 8'd0;
						end
						scl_d = 1'b0; delay_d = dly2; phase_d = i2c_mbe_pkg::PH_2;
					end else if (phase_d == i2c_mbe_pkg::PH_2) begin
						scl_d = 1'b1; shift_d = {shift_d[6:0], sda_in};
						bit_d = bit_inc; delay_d = dly1;
						phase_d = (bit_inc < i2c_mbe_pkg::BITS_PER_BYTE) ?
							i2c_mbe_pkg::PH_1 : i2c_mbe_pkg::PH_3;
					end else begin
						rx_d = shift_d; done_d = 1'b1;
					end
				end
				i2c_mbe_pkg::CMD_WACK: begin
					if (phase_d == i2c_mbe_pkg::PH_0) begin
						dir_d = 1'b0; sda_d = 1'b1; delay_d = dly1; phase_d = i2c_mbe_pkg::PH_1;
					end else if (phase_d == i2c_mbe_pkg::PH_1) begin
						scl_d = 1'b1; delay_d = dly1; phase_d = i2c_mbe_pkg::PH_2;
					end else if (!sda_in) begin
						scl_d = 1'b0; fail_d = 1'b0; done_d = 1'b1;
					end else begin
						poll_d = poll_inc;
						if (poll_inc > ack_timeout_q) begin
							// timeout: flag it and run the stop sequence from this tick
							fail_d = 1'b1; dir_d = 1'b1;
							if (ut_zero) begin
								scl_d = 1'b1; sda_d = 1'b1; done_d = 1'b1;
							end else begin
								cmd_d = i2c_mbe_pkg::CMD_STOP; scl_d = 1'b0; sda_d = 1'b0;
								delay_d = dly4; phase_d = i2c_mbe_pkg::PH_1;
							end
						end
					end
				end
				i2c_mbe_pkg::CMD_ACK, i2c_mbe_pkg::CMD_NACK: begin
					if (phase_d == i2c_mbe_pkg::PH_0) begin
						scl_d = 1'b0; dir_d = 1'b1;
						sda_d = (cmd_d == i2c_mbe_pkg::CMD_NACK);
						delay_d = dly2; phase_d = i2c_mbe_pkg::PH_1;
					end else if (phase_d == i2c_mbe_pkg::PH_1) begin
						scl_d = 1'b1; delay_d = dly2; phase_d = i2c_mbe_pkg::PH_2;
					end else begin
						scl_d = 1'b0; done_d = 1'b1;
					end
				end
				default: begin
					done_d = 1'b1;
				end
			endcase
		end

		if (done_d) begin
			cmd_d   = i2c_mbe_pkg::CMD_NONE;
			phase_d = i2c_mbe_pkg::PH_0;
			delay_d = '0;
		end

		res_d            = '0;
		res_d.scl_level  = scl_d;
		res_d.sda_level  = sda_d;
		res_d.sda_driven = dir_d;
		res_d.busy_res   = (cmd_d != i2c_mbe_pkg::CMD_NONE);
		res_d.done_res   = done_d;
		res_d.rx_byte    = rx_d;
		res_d.ack_failed = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= i2c_mbe_pkg::UNIT_TICKS_RST;
			ack_timeout_q <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_wen) begin
			if (cfg_index == i2c_mbe_pkg::REG_UNIT_TICKS) begin
				unit_ticks_q <= cfg_wdata;
			end else begin
				ack_timeout_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			dir_q     <= 1'b1;
			fail_q    <= 1'b0;
			cmd_q     <= i2c_mbe_pkg::CMD_NONE;
			phase_q   <= i2c_mbe_pkg::PH_0;
			delay_q   <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			poll_q    <= '0;
			rx_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				dir_q   <= dir_d;
				fail_q  <= fail_d;
				cmd_q   <= cmd_d;
				phase_q <= phase_d;
				delay_q <= delay_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				poll_q  <= poll_d;
				rx_q    <= rx_d;
			end
			if (in_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q == i2c_mbe_pkg::CMD_NONE |-> (delay_q == '0 && phase_q == i2c_mbe_pkg::PH_0))
		else $error("idle engine holds a pending delay or step");

	a_bitcnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= i2c_mbe_pkg::BITS_PER_BYTE)
		else $error("bit counter past one byte");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("done reported while still busy");

	a_timeout_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> (cmd_q == i2c_mbe_pkg::CMD_STOP || res_q.done_res))
		else $error("ack timeout did not start the stop sequence");

endmodule

`default_nettype wire

// File: tb/sv/tb_i2c_master_bit_engine.sv
// Self-checking testbench for the I2C master bit engine: per-tick results vs predictor or table.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
	import i2c_mbe_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SEGMENTS    = 10;
	localparam int SEG_TICKS   = 25;
	localparam int HOLD_OFF    = 300;
	localparam int SDA_RELEASE = 270;   // filler ticks before SDA is pulled low
	localparam int MAX_PRINTS  = 100;

	typedef enum logic [1:0] {STEP_ON, STEP_WAIT, STEP_END} step_t;

	typedef struct packed {
		logic [7:0] unit_cfg;
		logic [7:0] tmo_cfg;
		logic [2:0] func;
		logic [7:0] tx;
		logic       sda;
		logic       noise;
		logic       typed;
		logic       w_scl;
		logic       w_sda;
		logic       w_dir;
		logic       w_done;
		logic [7:0] w_rx;
		logic       w_fail;
	} plan_row_t;

	// unit, timeout, func, tx, sda, noise, typed | scl, sda, driven, done, rx, fail
	localparam int N_DIRECTED = 20;
	localparam plan_row_t DIRECTED [N_DIRECTED] = '{
		'{8'd32,  8'd250, CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
		'{8'd0,   8'd250, CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd250, CMD_READ,  8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0},
		'{8'd0,   8'd250, CMD_READ,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_WACK,  8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
		'{8'd0,   8'd0,   CMD_WACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_WRITE, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_ACK,   8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_NACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd0,   8'd0,   CMD_STOP,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'd1,   8'd20,  CMD_WACK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd1,   8'd255, CMD_WACK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd1,   8'd255, CMD_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd2,   8'd3,   CMD_READ,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd1,   8'd3,   CMD_WACK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd255, 8'd8,   CMD_WACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd1,   8'd8,   CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd3,   8'd8,   CMD_ACK,   8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'd3,   8'd8,   CMD_NACK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_wen = 1'b0;
	logic        cfg_index = REG_UNIT_TICKS;
	logic [7:0]  cfg_wdata = '0;

	i2c_master_bit_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// engine mirror
	logic [7:0]         bus_unit = UNIT_TICKS_RST;
	logic [7:0]         bus_timeout = ACK_TIMEOUT_RST;
	logic               bus_scl = 1'b1, bus_sda = 1'b1, bus_dir = 1'b1, bus_fail = 1'b0;
	logic [FUNC_W-1:0]  bus_cmd = CMD_NONE;
	logic [PHASE_W-1:0] bus_ph = PH_0;
	logic [DELAY_W-1:0] bus_dly = '0;
	logic [3:0]         bus_bits = '0;
	logic [7:0]         bus_shift = '0, bus_polls = '0, bus_rx = '0;

	res_t line_q[$];
	res_t got_res, want_res;
	int   src_idle_pct = 24, dst_idle_pct = 65;
	int   stall_ask = 0, stall_left = 0;
	int   ack_low_pct = 10;
	int   err_count = 0, n_sent = 0, n_checked = 0, n_cmds = 0, n_timeouts = 0, n_writes = 0;
	int   cycles = 0;

	function automatic step_t arm_delay(input int units, input logic [PHASE_W-1:0] next);
		int span;
		span = units * int'(bus_unit);
		bus_dly = span[DELAY_W-1:0];
		bus_ph = next;
		return (bus_dly != '0) ? STEP_WAIT : STEP_ON;
	endfunction

	function automatic step_t run_step(input logic sda);
		case (bus_cmd)
			CMD_START: begin
				if (bus_ph == PH_0) begin
					bus_dir = 1'b1; bus_sda = 1'b1; bus_scl = 1'b1;
					return arm_delay(4, PH_1);
				end
				if (bus_ph == PH_1) begin
					bus_sda = 1'b0;
					return arm_delay(4, PH_2);
				end
				bus_scl = 1'b0;
				return STEP_END;
			end
			CMD_STOP: begin
				if (bus_ph == PH_0) begin
					bus_dir = 1'b1; bus_scl = 1'b0; bus_sda = 1'b0;
					return arm_delay(4, PH_1);
				end
				if (bus_ph == PH_1) begin
					bus_scl = 1'b1; bus_sda = 1'b1;
					return arm_delay(4, PH_2);
				end
				return STEP_END;
			end
			CMD_WRITE: begin
				if (bus_ph == PH_0) begin
					bus_dir = 1'b1; bus_scl = 1'b0; bus_ph = PH_1;
					return STEP_ON;
				end
				if (bus_ph == PH_1) begin
					bus_sda = bus_shift[7];
					bus_shift = {bus_shift[6:0], 1'b0};
					return arm_delay(2, PH_2);
				end
				if (bus_ph == PH_2) begin
					bus_scl = 1'b1;
					return arm_delay(2, PH_3);
				end
				if (bus_ph == PH_3) begin
					bus_scl = 1'b0;
					bus_bits = bus_bits + 4'd1;
					return arm_delay(2, (bus_bits < BITS_PER_BYTE) ? PH_1 : PH_4);
				end
				return STEP_END;
			end
			CMD_READ: begin
				if (bus_ph == PH_0) begin
					bus_dir = 1'b0; bus_shift = '0; bus_ph = PH_1;
					return STEP_ON;
				end
				if (bus_ph == PH_1) begin
					bus_scl = 1'b0;
					return arm_delay(2, PH_2);
				end
				if (bus_ph == PH_2) begin
					bus_scl = 1'b1;
					bus_shift = {bus_shift[6:0], sda};
					bus_bits = bus_bits + 4'd1;
					return arm_delay(1, (bus_bits < BITS_PER_BYTE) ? PH_1 : PH_3);
				end
				bus_rx = bus_shift;
				return STEP_END;
			end
			CMD_WACK: begin
				if (bus_ph == PH_0) begin
					bus_dir = 1'b0; bus_sda = 1'b1;
					return arm_delay(1, PH_1);
				end
				if (bus_ph == PH_1) begin
					bus_scl = 1'b1;
					return arm_delay(1, PH_2);
				end
				if (!sda) begin
					bus_scl = 1'b0; bus_fail = 1'b0;
					return STEP_END;
				end
				if (bus_polls != POLL_MAX)
					bus_polls = bus_polls + 8'd1;
				// too many high polls: flag it and fall into the stop sequence
				if (bus_polls > bus_timeout) begin
					bus_fail = 1'b1;
					bus_cmd = CMD_STOP;
					bus_ph = PH_0;
					n_timeouts++;
					return STEP_ON;
				end
				return STEP_WAIT;
			end
			CMD_ACK, CMD_NACK: begin
				if (bus_ph == PH_0) begin
					bus_scl = 1'b0; bus_dir = 1'b1;
					bus_sda = (bus_cmd == CMD_NACK);
					return arm_delay(2, PH_1);
				end
				if (bus_ph == PH_1) begin
					bus_scl = 1'b1;
					return arm_delay(2, PH_2);
				end
				bus_scl = 1'b0;
				return STEP_END;
			end
			default: return STEP_END;
		endcase
	endfunction

	function automatic res_t advance_engine(input logic [2:0] func, input logic [7:0] tx,
			input logic sda);
		logic  go;
		logic  done;
		step_t r;
		res_t  o;
		go = 1'b0;
		done = 1'b0;
		if (bus_cmd == CMD_NONE) begin
			if (func != CMD_NONE) begin
				bus_cmd = func;
				bus_ph = PH_0; bus_dly = '0; bus_bits = '0; bus_polls = '0;
				bus_shift = (func == CMD_WRITE) ? tx : 8'h00;
				go = 1'b1;
				n_cmds++;
			end
		end else if (bus_dly != '0) begin
			bus_dly = bus_dly - 10'd1;
			go = (bus_dly == '0);
		end else begin
			go = 1'b1;
		end
		// all zero-delay steps resolve within this tick
		while (go) begin
			r = run_step(sda);
			if (r == STEP_END) begin
				bus_cmd = CMD_NONE;
				bus_ph = PH_0;
				done = 1'b1;
				go = 1'b0;
			end else if (r == STEP_WAIT) begin
				go = 1'b0;
			end
		end
		o = '0;
		o.scl_level  = bus_scl;
		o.sda_level  = bus_sda;
		o.sda_driven = bus_dir;
		o.busy_res   = (bus_cmd != CMD_NONE);
		o.done_res   = done;
		o.rx_byte    = bus_rx;
		o.ack_failed = bus_fail;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("[%0t] result %0d %s: got %0h, expected %0h", $time, n_checked, what,
				got, want);
	endtask

	task automatic drive_tick(input logic [2:0] func, input logic [7:0] tx, input logic sda,
			input logic typed, input res_t want);
		res_t model_out;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, sda, tx, func};
		do @(posedge clk); while (!s_axis_tready);
		model_out = advance_engine(func, tx, sda);
		line_q.push_back(typed ? want : model_out);
		n_sent++;
	endtask

	task automatic random_tick(input logic may_start);
		logic [2:0] func;
		logic       sda;
		func = CMD_NONE;
		if (bus_cmd == CMD_NONE) begin
			if (may_start && $urandom_range(0, 99) < 60) begin
				func = 3'($urandom_range(1, 7));
				if (func == CMD_WACK) begin
					case ($urandom_range(0, 2))
						0: ack_low_pct = 0;
						1: ack_low_pct = 10;
						default: ack_low_pct = 50;
					endcase
					// a never-low SDA with no timeout would hang the engine
					if (bus_timeout == POLL_MAX && ack_low_pct == 0)
						ack_low_pct = 10;
				end
			end
		end else if ($urandom_range(0, 9) == 0) begin
			func = 3'($urandom_range(0, 7));   // ignored while busy
		end
		if (bus_cmd == CMD_WACK || (bus_cmd == CMD_NONE && func == CMD_WACK))
			sda = ($urandom_range(0, 99) >= ack_low_pct);
		else
			sda = 1'($urandom_range(0, 1));
		drive_tick(func, 8'($urandom_range(0, 255)), sda, 1'b0, '0);
	endtask

	// park the source and let every outstanding result drain
	task automatic hold_source();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (line_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_UNIT_TICKS)
			bus_unit = val;
		else
			bus_timeout = val;
		n_writes++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_ask != 0) begin
			stall_left = stall_ask;
			stall_ask = 0;
		end
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = res_t'(m_axis_tdata);
			if (line_q.size() == 0) begin
				report_mismatch("arrived with nothing expected", m_axis_tdata, 0);
			end else begin
				want_res = line_q.pop_front();
				if (got_res.scl_level != want_res.scl_level)
					report_mismatch("scl_level", got_res.scl_level, want_res.scl_level);
				if (got_res.sda_level != want_res.sda_level)
					report_mismatch("sda_level", got_res.sda_level, want_res.sda_level);
				if (got_res.sda_driven != want_res.sda_driven)
					report_mismatch("sda_driven", got_res.sda_driven, want_res.sda_driven);
				if (got_res.busy_res != want_res.busy_res)
					report_mismatch("busy_res", got_res.busy_res, want_res.busy_res);
				if (got_res.done_res != want_res.done_res)
					report_mismatch("done_res", got_res.done_res, want_res.done_res);
				if (got_res.rx_byte != want_res.rx_byte)
					report_mismatch("rx_byte", got_res.rx_byte, want_res.rx_byte);
				if (got_res.ack_failed != want_res.ack_failed)
					report_mismatch("ack_failed", got_res.ack_failed, want_res.ack_failed);
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, line_q.size());
			$display("tb_i2c_master_bit_engine: errors");
			$finish;
		end
	end

	initial begin
		plan_row_t row;
		res_t      want;
		int        fill;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: one command per row, run to completion with filler ticks
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			if (row.unit_cfg != bus_unit || row.tmo_cfg != bus_timeout) begin
				hold_source();
				set_register(REG_UNIT_TICKS, row.unit_cfg);
				set_register(REG_ACK_TIMEOUT, row.tmo_cfg);
			end
			want = '0;
			want.scl_level  = row.w_scl;
			want.sda_level  = row.w_sda;
			want.sda_driven = row.w_dir;
			want.done_res   = row.w_done;
			want.rx_byte    = row.w_rx;
			want.ack_failed = row.w_fail;
			drive_tick(row.func, row.tx, row.sda, row.typed, want);
			fill = 0;
			while (bus_cmd != CMD_NONE) begin
				drive_tick(row.noise ? 3'($urandom_range(0, 7)) : CMD_NONE,
					8'($urandom_range(0, 255)), (fill < SDA_RELEASE) ? row.sda : 1'b0,
					1'b0, '0);
				fill++;
			end
		end

		// random command streams, one setting of both registers per segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 4) begin
				src_idle_pct = 24; dst_idle_pct = 65;
			end else if (seg < 7) begin
				src_idle_pct = 65; dst_idle_pct = 24;
			end else begin
				src_idle_pct = 0; dst_idle_pct = 0;
			end
			hold_source();
			case ($urandom_range(0, 9))
				0: set_register(REG_UNIT_TICKS, 8'd0);
				9: set_register(REG_UNIT_TICKS, 8'($urandom_range(4, 16)));
				default: set_register(REG_UNIT_TICKS, 8'($urandom_range(1, 3)));
			endcase
			case ($urandom_range(0, 3))
				0: set_register(REG_ACK_TIMEOUT, 8'd0);
				1: set_register(REG_ACK_TIMEOUT, 8'd255);
				2: set_register(REG_ACK_TIMEOUT, 8'($urandom_range(1, 8)));
				default: set_register(REG_ACK_TIMEOUT, 8'($urandom_range(0, 255)));
			endcase
			if (seg == 1 || seg == 8)
				stall_ask = HOLD_OFF;   // sink stalls; the source keeps offering ticks but waits on s_axis_tready
			for (int k = 0; k < SEG_TICKS; k++)
				random_tick(1'b1);
			while (bus_cmd != CMD_NONE)
				random_tick(1'b0);
		end

		hold_source();
		repeat (4) @(posedge clk);
		$display("run: %0d ticks sent, %0d results checked, %0d register writes", n_sent,
			n_checked, n_writes);
		$display("run: %0d commands started, %0d acknowledge timeouts, sink held off twice",
			n_cmds, n_timeouts);
		if (err_count == 0)
			$display("tb_i2c_master_bit_engine: clean");
		else
			$display("tb_i2c_master_bit_engine: errors");
		$finish;
	end

endmodule
